// ===== hdl/lccd_pkg.sv =====
`timescale 1ns / 1ps

package lccd_pkg;

  // default widths of the sample and pixel counter paths
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 12;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  // register field widths
  localparam int SKIP_BITS   = 6;
  localparam int HEADER_BITS = 4;
  localparam int SIG_BITS    = 12;
  localparam int WAIT_BITS   = 24;

  // register reset values
  localparam logic [SKIP_BITS-1:0]   LEAD_RST   = SKIP_BITS'(16);
  localparam logic [SKIP_BITS-1:0]   SHIELD_RST = SKIP_BITS'(13);
  localparam logic [HEADER_BITS-1:0] HEADER_RST = HEADER_BITS'(3);
  localparam logic [SIG_BITS-1:0]    SIG_RST    = SIG_BITS'(3648);
  localparam logic [SKIP_BITS-1:0]   TRAIL_RST  = SKIP_BITS'(14);
  localparam logic [WAIT_BITS-1:0]   INTEG_RST  = WAIT_BITS'(100);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEAD   = 3'd0,
    REG_SHIELD = 3'd1,
    REG_HEADER = 3'd2,
    REG_SIGNAL = 3'd3,
    REG_TRAIL  = 3'd4,
    REG_INTEG  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SKIP_BITS-1:0]   lead_count;
    logic [SKIP_BITS-1:0]   shield_count;
    logic [HEADER_BITS-1:0] header_count;
    logic [SIG_BITS-1:0]    sig_count;
    logic [SKIP_BITS-1:0]   trail_count;
    logic [WAIT_BITS-1:0]   integ_ticks;
  } lccd_cfg_t;

endpackage

// ===== hdl/lccd_regs.sv =====
`timescale 1ns / 1ps

module lccd_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [lccd_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [lccd_pkg::CFG_DATA_BITS-1:0]  wr_data,
  output lccd_pkg::lccd_cfg_t                 cfg
);
  import lccd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lead_count   <= LEAD_RST;
      cfg.shield_count <= SHIELD_RST;
      cfg.header_count <= HEADER_RST;
      cfg.sig_count    <= SIG_RST;
      cfg.trail_count  <= TRAIL_RST;
      cfg.integ_ticks  <= INTEG_RST;
    end else if (wr_en) begin
      // unknown indexes are dropped, upper data bits ignored
      case (wr_index)
        REG_LEAD:   cfg.lead_count   <= wr_data[SKIP_BITS-1:0];
        REG_SHIELD: cfg.shield_count <= wr_data[SKIP_BITS-1:0];
        REG_HEADER: cfg.header_count <= wr_data[HEADER_BITS-1:0];
        REG_SIGNAL: cfg.sig_count    <= wr_data[SIG_BITS-1:0];
        REG_TRAIL:  cfg.trail_count  <= wr_data[SKIP_BITS-1:0];
        REG_INTEG:  cfg.integ_ticks  <= wr_data[WAIT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/linear_ccd_readout_sequencer_unit.sv =====
`timescale 1ns / 1ps
// a tick accepted into the input register passes on into the result register
// throughput: one tick per cycle while the result register is not stalled; the sequencer
//   state updates as a tick moves from input to result register: one phase step per tick
// reset: registers back to their defaults, phase idle, gate high, busy and ready low,
//   input and result registers empty

module linear_ccd_readout_sequencer_unit #(
  parameter int SAMPLE_BITS = lccd_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = lccd_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // tick input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                start_pressed,
  input  logic [SAMPLE_BITS-1:0]              sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                gate_level,
  output logic                                busy_res,
  output logic                                ready_res,
  output logic                                pixel_valid,
  output logic [COUNT_BITS-1:0]               pixel_index,
  output logic [SAMPLE_BITS-1:0]              pixel_value,
  output logic                                frame_last,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lccd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lccd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import lccd_pkg::*;

  // compare width for segment counter against the skip and signal counts
  localparam int CMP_BITS = (COUNT_BITS > SIG_BITS) ? COUNT_BITS : SIG_BITS;

  // one-hot sequencer phases
  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_BEGIN  = 10'b00_0000_0010,
    PH_ACTIVE = 10'b00_0000_0100,
    PH_LEAD   = 10'b00_0000_1000,
    PH_SHIELD = 10'b00_0001_0000,
    PH_HEADER = 10'b00_0010_0000,
    PH_SIGNAL = 10'b00_0100_0000,
    PH_TRAIL  = 10'b00_1000_0000,
    PH_INTEG  = 10'b01_0000_0000,
    PH_FINISH = 10'b10_0000_0000
  } phase_t;

  // configuration registers; writes are always taken
  lccd_cfg_t cfg;

  assign cfg_ready = 1'b1;

  lccd_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input register: holds one tick while the result register is stalled
  logic                   s1_valid;
  logic                   s1_start;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   advance;

  assign advance  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_start  <= start_pressed;
      s1_sample <= sample;
    end
  end

  // sequencer state
  phase_t                 phase, phase_next;
  logic [COUNT_BITS-1:0]  segment_counter, segment_counter_next;
  logic [WAIT_BITS-1:0]   wait_counter, wait_counter_next;
  logic                   gate_reg, gate_reg_next;
  logic                   busy_reg, busy_reg_next;
  logic                   ready_reg, ready_reg_next;

  // per-tick result before registering
  logic                   pix_valid_c;
  logic [COUNT_BITS-1:0]  pix_index_c;
  logic [SAMPLE_BITS-1:0] pix_value_c;
  logic                   last_c;

  // segment bookkeeping shared by the four skip segments and the signal run
  logic [COUNT_BITS-1:0]  seg_inc;
  logic [CMP_BITS-1:0]    seg_limit;
  logic                   seg_done;
  logic                   wait_done;

  assign seg_inc = segment_counter + COUNT_BITS'(1);

  always_comb begin
    case (phase)
      PH_LEAD:   seg_limit = CMP_BITS'(cfg.lead_count);
      PH_SHIELD: seg_limit = CMP_BITS'(cfg.shield_count);
      PH_HEADER: seg_limit = CMP_BITS'(cfg.header_count);
      PH_SIGNAL: seg_limit = CMP_BITS'(cfg.sig_count);
      PH_TRAIL:  seg_limit = CMP_BITS'(cfg.trail_count);
      default:   seg_limit = '0;
    endcase
  end

  // a zero count, or a counter wrap, still closes the segment
  assign seg_done  = (CMP_BITS'(seg_inc) >= seg_limit) | (seg_inc == '0);
  // the integration wait counts up to integ_ticks, then the finish phase counts up to it again
  assign wait_done = ~(wait_counter < cfg.integ_ticks);

  always_comb begin
    phase_next           = phase;
    segment_counter_next = segment_counter;
    wait_counter_next    = wait_counter;
    gate_reg_next        = gate_reg;
    busy_reg_next        = busy_reg;
    ready_reg_next       = ready_reg;
    pix_valid_c          = 1'b0;
    pix_index_c          = '0;
    pix_value_c          = '0;
    last_c               = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (s1_start) begin
          gate_reg_next = 1'b0;
          phase_next    = PH_BEGIN;
        end else if (gate_reg) begin
          ready_reg_next = 1'b1;
        end
      end
      PH_BEGIN: begin
        busy_reg_next = 1'b1;
        phase_next    = PH_ACTIVE;
      end
      PH_ACTIVE: begin
        gate_reg_next        = 1'b1;
        segment_counter_next = '0;
        phase_next           = PH_LEAD;
      end
      PH_LEAD, PH_SHIELD, PH_HEADER: begin
        segment_counter_next = seg_done ? '0 : seg_inc;
        if (seg_done) begin
          case (phase)
            PH_LEAD:   phase_next = PH_SHIELD;
            PH_SHIELD: phase_next = PH_HEADER;
            default:   phase_next = PH_SIGNAL;
          endcase
        end
      end
      PH_SIGNAL: begin
        pix_valid_c          = 1'b1;
        pix_index_c          = segment_counter;
        pix_value_c          = s1_sample;
        segment_counter_next = seg_done ? '0 : seg_inc;
        if (seg_done) begin
          last_c     = 1'b1;
          phase_next = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        segment_counter_next = seg_done ? '0 : seg_inc;
        if (seg_done) begin
          // trailing dummies done: close the gate for integration
          gate_reg_next     = 1'b0;
          wait_counter_next = '0;
          phase_next        = PH_INTEG;
        end
      end
      PH_INTEG: begin
        wait_counter_next = wait_done ? '0 : wait_counter + WAIT_BITS'(1);
        if (wait_done) begin
          phase_next = PH_FINISH;
        end
      end
      PH_FINISH: begin
        wait_counter_next = wait_done ? '0 : wait_counter + WAIT_BITS'(1);
        if (wait_done) begin
          busy_reg_next = 1'b0;
          gate_reg_next = 1'b1;
          phase_next    = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // state moves only when a tick passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      segment_counter <= '0;
      wait_counter    <= '0;
      gate_reg        <= 1'b1;
      busy_reg        <= 1'b0;
      ready_reg       <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      segment_counter <= segment_counter_next;
      wait_counter    <= wait_counter_next;
      gate_reg        <= gate_reg_next;
      busy_reg        <= busy_reg_next;
      ready_reg       <= ready_reg_next;
    end
  end

  // result register, levels shown are those after the tick's update
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gate_level  <= gate_reg_next;
      busy_res    <= busy_reg_next;
      ready_res   <= ready_reg_next;
      pixel_valid <= pix_valid_c;
      pixel_index <= pix_index_c;
      pixel_value <= pix_value_c;
      frame_last  <= last_c;
    end
  end

endmodule

// ===== hdl/lccd_chk.sv =====
`timescale 1ns / 1ps

module lccd_chk #(
  parameter int SAMPLE_BITS = lccd_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = lccd_pkg::COUNT_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_ready,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   busy_res,
  input logic                   pixel_valid,
  input logic [COUNT_BITS-1:0]  pixel_index,
  input logic [SAMPLE_BITS-1:0] pixel_value,
  input logic                   frame_last
);

  // signal pixels only come out during a busy frame
  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_valid |-> busy_res)
    else $error("pixel beat outside busy frame");

  // non-pixel beats carry zeroed pixel fields
  a_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> pixel_index == '0 && pixel_value == '0 && !frame_last)
    else $error("pixel fields not cleared on non-pixel beat");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_index) && $stable(pixel_value))
    else $error("stalled result beat changed");

endmodule

bind linear_ccd_readout_sequencer_unit lccd_chk #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .COUNT_BITS  (COUNT_BITS)
) u_chk (
  .clk         (clk),
  .rst         (rst),
  .cfg_ready   (cfg_ready),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .busy_res    (busy_res),
  .pixel_valid (pixel_valid),
  .pixel_index (pixel_index),
  .pixel_value (pixel_value),
  .frame_last  (frame_last)
);
